/* rtl/dqnh_pkg.sv */
`default_nettype none

package dqnh_pkg;

  // Name walk limits
  localparam int MaxLabels      = 10;
  localparam int LabelHashBytes = 32;
  localparam int NameLimit      = 160;

  // FNV-1a 32
  localparam logic [31:0] HASH_MULT  = 32'd16777619;
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  // Status codes; a verdict of zero means no check has failed yet
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd1;
  localparam logic [2:0] ST_NOT_UDP   = 3'd2;
  localparam logic [2:0] ST_PORT      = 3'd3;
  localparam logic [2:0] ST_RESPONSE  = 3'd4;
  localparam logic [2:0] ST_MALFORMED = 3'd5;

  // Register indexes
  localparam logic REG_DNS_PORT = 1'b0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] name_hash;
    logic [15:0] query_type;
  } out_beat_t;

endpackage

`default_nettype wire

/* rtl/dqnh_cfg.sv */
`default_nettype none

module dqnh_cfg
  import dqnh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      dns_port
);

  logic [15:0] dns_port_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_DNS_PORT);

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dns_port_r <= DNS_PORT_RESET;
    end else if (wr_en) begin
      dns_port_r <= pwdata[15:0];
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_DNS_PORT) begin
      prdata = {16'd0, dns_port_r};
    end
  end

  assign dns_port = dns_port_r;

endmodule

`default_nettype wire

/* rtl/dqnh_parser.sv */
`default_nettype none

module dqnh_parser
  import dqnh_pkg::*;
#(
  parameter int MAX_LABELS       = MaxLabels,
  parameter int LABEL_HASH_BYTES = LabelHashBytes,
  parameter int NAME_LIMIT       = NameLimit
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire in_beat_t    beat,
  input  wire logic [15:0] dns_port,
  output out_beat_t        result
);

  typedef enum logic [6:0] {
    PH_HEADERS = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_BODY    = 7'b0000100,
    PH_QT_HI   = 7'b0001000,
    PH_QT_LO   = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_FAIL    = 7'b1000000
  } phase_t;

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [5:0]  header_len_r, header_len_nxt;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [7:0]  name_off_r, name_off_nxt;
  logic [3:0]  label_cnt_r, label_cnt_nxt;
  logic [7:0]  label_rem_r, label_rem_nxt;
  logic [5:0]  label_hashed_r, label_hashed_nxt;
  logic [15:0] qtype_r, qtype_nxt;
  phase_t      phase_r, phase_nxt;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic [15:0] udp_off;
  logic [8:0]  name_off_inc;
  logic [7:0]  label_rem_dec;
  logic [2:0]  v;
  logic [2:0]  st;

  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] code,
                                      input logic hit);
    flag = (hit && (cur == ST_PENDING || code < cur)) ? code : cur;
  endfunction

  assign b             = beat.frame_byte;
  assign udp_off       = 16'd14 + {10'd0, header_len_r};
  assign name_off_inc  = {1'b0, name_off_r} + 9'd1;
  assign label_rem_dec = label_rem_r - 8'd1;

  // Lower-case A-Z only
  always_comb begin
    lc = b;
    if (b inside {[8'h41:8'h5A]}) begin
      lc = b + 8'd32;
    end
  end

  // Per-byte parse step
  always_comb begin
    byte_offset_nxt  = (byte_offset_r != 16'hFFFF) ? byte_offset_r + 16'd1 : byte_offset_r;
    header_len_nxt   = header_len_r;
    verdict_nxt      = verdict_r;
    hash_nxt         = hash_r;
    name_off_nxt     = name_off_r;
    label_cnt_nxt    = label_cnt_r;
    label_rem_nxt    = label_rem_r;
    label_hashed_nxt = label_hashed_r;
    qtype_nxt        = qtype_r;
    phase_nxt        = phase_r;
    v                = verdict_r;

    case (phase_r)
      PH_HEADERS: begin
        v = flag(v, ST_NOT_IPV4, (byte_offset_r == 16'd12) && (b != 8'h08));
        v = flag(v, ST_NOT_IPV4, (byte_offset_r == 16'd13) && (b != 8'h00));
        if (byte_offset_r == 16'd14) begin
          header_len_nxt = {b[3:0], 2'b00};
        end
        v = flag(v, ST_NOT_UDP, (byte_offset_r == 16'd23) && (b != 8'd17));
        if (byte_offset_r > 16'd14) begin
          v = flag(v, ST_PORT, (byte_offset_r == udp_off + 16'd2) && (b != dns_port[15:8]));
          v = flag(v, ST_PORT, (byte_offset_r == udp_off + 16'd3) && (b != dns_port[7:0]));
          v = flag(v, ST_RESPONSE, (byte_offset_r == udp_off + 16'd10) && b[7]);
          if (byte_offset_r == udp_off + 16'd19) begin
            phase_nxt = (v == ST_PENDING) ? PH_LEN : PH_FAIL;
          end
        end
        verdict_nxt = v;
      end
      PH_LEN: begin
        if (label_cnt_r >= 4'(MAX_LABELS) || name_off_inc > 9'(NAME_LIMIT)) begin
          verdict_nxt = flag(verdict_r, ST_MALFORMED, 1'b1);
          phase_nxt   = PH_FAIL;
        end else begin
          name_off_nxt = name_off_inc[7:0];
          if (b == 8'd0) begin
            phase_nxt = PH_QT_HI;
          end else if (name_off_inc + {1'b0, b} > 9'(NAME_LIMIT)) begin
            verdict_nxt = flag(verdict_r, ST_MALFORMED, 1'b1);
            phase_nxt   = PH_FAIL;
          end else begin
            label_rem_nxt    = b;
            label_hashed_nxt = 6'd0;
            phase_nxt        = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (label_hashed_r < 6'(LABEL_HASH_BYTES)) begin
          hash_nxt         = (hash_r ^ {24'd0, lc}) * HASH_MULT;
          label_hashed_nxt = label_hashed_r + 6'd1;
        end
        name_off_nxt  = name_off_inc[7:0];
        label_rem_nxt = label_rem_dec;
        if (label_rem_dec == 8'd0) begin
          label_cnt_nxt = label_cnt_r + 4'd1;
          phase_nxt     = PH_LEN;
        end
      end
      PH_QT_HI: begin
        qtype_nxt = {b, 8'd0};
        phase_nxt = PH_QT_LO;
      end
      PH_QT_LO: begin
        qtype_nxt = {qtype_r[15:8], b};
        phase_nxt = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // Frame outcome, taken on the last beat
  always_comb begin
    if (verdict_nxt != ST_PENDING) begin
      st = verdict_nxt;
    end else if (phase_nxt == PH_DONE) begin
      st = ST_OK;
    end else begin
      st = ST_MALFORMED;
    end
    result.status     = st;
    result.name_hash  = (st == ST_OK) ? hash_nxt : 32'd0;
    result.query_type = (st == ST_OK) ? qtype_nxt : 16'd0;
  end

  // State registers; the last beat of a frame returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat.frame_end)) begin
      byte_offset_r  <= 16'd0;
      header_len_r   <= 6'd0;
      verdict_r      <= ST_PENDING;
      hash_r         <= FNV_OFFSET;
      name_off_r     <= 8'd12;
      label_cnt_r    <= 4'd0;
      label_rem_r    <= 8'd0;
      label_hashed_r <= 6'd0;
      qtype_r        <= 16'd0;
      phase_r        <= PH_HEADERS;
    end else if (step) begin
      byte_offset_r  <= byte_offset_nxt;
      header_len_r   <= header_len_nxt;
      verdict_r      <= verdict_nxt;
      hash_r         <= hash_nxt;
      name_off_r     <= name_off_nxt;
      label_cnt_r    <= label_cnt_nxt;
      label_rem_r    <= label_rem_nxt;
      label_hashed_r <= label_hashed_nxt;
      qtype_r        <= qtype_nxt;
      phase_r        <= phase_nxt;
    end
  end

  // Name walk starts only after the whole DNS header has gone by
  a_name_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADERS) |-> (byte_offset_r >= 16'd34))
    else $error("name phase entered before DNS header end");

  // A frame's last beat leaves the parser in its reset state
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && beat.frame_end) |=> (byte_offset_r == 16'd0 && phase_r == PH_HEADERS
                                  && verdict_r == ST_PENDING && hash_r == FNV_OFFSET))
    else $error("parser state not cleared after frame end");

  // The fail phase always carries a verdict, from a header check or the name walk
  a_fail_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FAIL) |-> (verdict_r != ST_PENDING))
    else $error("fail phase without verdict");

endmodule

`default_nettype wire

/* rtl/dns_query_name_hasher_top.sv */
// Channel  | Ports                               | Beat
// ---------+-------------------------------------+--------------------------------
// input    | in_valid, in_ready, in_data         | one frame byte, frame_end flag
// result   | out_valid, out_ready, out_data      | status, name_hash, query_type
// config   | psel, penable, pwrite, paddr, ...   | dns_port at byte address 0
//
// One frame byte per cycle sustained; a beat goes through an input register,
// then one parse step (one XOR and one 32-bit constant multiply for the hash).
// out_valid comes from the result register, loaded by the frame's last parse step.
// Reset is synchronous, active low; it clears all parse state and sets dns_port to 53.
// A held result stalls input only when the next frame end reaches the parse step.
`default_nettype none

module dns_query_name_hasher_top
  import dqnh_pkg::*;
#(
  parameter int MAX_LABELS       = MaxLabels,
  parameter int LABEL_HASH_BYTES = LabelHashBytes,
  parameter int NAME_LIMIT       = NameLimit
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        in_v_r;
  in_beat_t    in_r;
  logic        out_v_r;
  out_beat_t   out_r;
  logic        step;
  logic        load;
  logic        in_acc;
  logic [15:0] dns_port;
  out_beat_t   result;

  dqnh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dns_port (dns_port)
  );

  // A byte moves into the parser unless it ends a frame and the result slot is held
  assign step     = in_v_r && !(in_r.frame_end && out_v_r && !out_ready);
  assign load     = step && in_r.frame_end;
  assign in_ready = !in_v_r || step;
  assign in_acc   = in_valid && in_ready;

  dqnh_parser #(
    .MAX_LABELS       (MAX_LABELS),
    .LABEL_HASH_BYTES (LABEL_HASH_BYTES),
    .NAME_LIMIT       (NAME_LIMIT)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .beat     (in_r),
    .dns_port (dns_port),
    .result   (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // A frame end never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |-> !load)
    else $error("result overwritten while held");

  // Hash and type are zero unless the query parsed
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status != ST_OK) |-> (out_r.name_hash == 32'd0
                                            && out_r.query_type == 16'd0))
    else $error("nonzero fields on failed frame");

  // A blocked frame end holds the input side
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && in_r.frame_end && out_v_r && !out_ready) |-> !in_ready)
    else $error("input taken while frame end is blocked");

endmodule

`default_nettype wire
